// ===== rtl/strict_priority_four_queue_scheduler_defines.svh =====
// Assertion macros for the strict priority four queue scheduler.
`ifndef STRICT_PRIORITY_FOUR_QUEUE_SCHEDULER_DEFINES_SVH
`define STRICT_PRIORITY_FOUR_QUEUE_SCHEDULER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a consequence holds in the same cycle as its antecedent.
`define SPQ_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Package with types, constants and helpers of the strict priority scheduler.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_CLASSES = 4;
    localparam int TICKET_BITS = 32;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CLS_W = 2;
    localparam int ADDR_W = CLS_W + PTR_W;
    localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int TIME_W = 11;
    localparam int PEAK_W = 9;
    localparam int STAT_W = 16;
    localparam int WAIT_LIMIT = 1439;
    localparam int COUNT_LIMIT = 65535;

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_SERVE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_SERVED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        op_t         opcode;
        logic [31:0] ticket;
        logic [1:0]  priority_class;
        logic [10:0] time_minutes;
        logic [1:0]  report_class;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] served_ticket;
        logic [1:0]  served_class;
        logic [10:0] wait_time;
        logic [6:0]  depth_emergency;
        logic [6:0]  depth_urgent;
        logic [6:0]  depth_less_urgent;
        logic [6:0]  depth_non_urgent;
        logic [15:0] total_served;
        logic [8:0]  peak_occupancy;
        logic [10:0] longest_wait;
        logic [15:0] class_served_count;
    } rsp_t;

    typedef struct packed {
        logic [TICKET_BITS-1:0] ticket;
        logic [TIME_W-1:0]      time_minutes;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    typedef struct packed {
        status_t                         status;
        logic [CLS_W-1:0]                cls;
        logic [TIME_W-1:0]               now;
        logic [CLS_W-1:0]                report_class;
        logic [NUM_CLASSES-1:0][CNT_W-1:0] depth;
        logic [PEAK_W-1:0]               peak;
    } stage_b_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
        return (v == STAT_W'(COUNT_LIMIT)) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/spq_store.sv =====
// Queue entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module spq_store
    import spq_pkg::*;
(
    input  logic       clk,
    input  store_req_t store_req,
    output entry_t     rd_data
);

    entry_t mem [STORE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (store_req.wr_en)
        begin
            mem[store_req.wr_addr] <= store_req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_req.rd_en)
        begin
            rd_data_reg <= mem[store_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/spq_queue_ctrl.sv =====
// Input register, queue pointers and counts, priority select and store access.
`timescale 1ns / 1ps

module spq_queue_ctrl
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       req_valid,
    input  req_t       req,
    output store_req_t store_req,
    output logic       b_valid,
    output stage_b_t   b_info
);

    logic              a_valid_reg;
    req_t              a_reg;
    ptr_t              head_reg [NUM_CLASSES];
    ptr_t              head_next [NUM_CLASSES];
    ptr_t              tail_reg [NUM_CLASSES];
    ptr_t              tail_next [NUM_CLASSES];
    count_t            count_reg [NUM_CLASSES];
    count_t            count_next [NUM_CLASSES];
    logic [PEAK_W-1:0] peak_reg;
    logic [PEAK_W-1:0] peak_next;

    logic [CLS_W-1:0]  arr_cls;
    logic [CLS_W-1:0]  sel_cls;
    logic              found;
    logic [PEAK_W-1:0] total;
    status_t           status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= req;
        end
    end

    always_comb
    begin
        if (int'(a_reg.priority_class) >= NUM_CLASSES)
        begin
            arr_cls = CLS_W'(NUM_CLASSES - 1);
        end
        else
        begin
            arr_cls = a_reg.priority_class;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        peak_next = peak_reg;
        status = ST_ADDED;
        sel_cls = '0;
        found = 1'b0;
        total = '0;
        store_req = '0;
        store_req.wr_data.ticket = a_reg.ticket[TICKET_BITS-1:0];
        store_req.wr_data.time_minutes = a_reg.time_minutes;
        case (a_reg.opcode)
            OP_ARRIVE:
            begin
                sel_cls = arr_cls;
                if (count_reg[arr_cls] >= CNT_W'(QUEUE_DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    store_req.wr_en = a_valid_reg && adv;
                    store_req.wr_addr = {arr_cls, tail_reg[arr_cls]};
                    tail_next[arr_cls] = ptr_inc(tail_reg[arr_cls]);
                    count_next[arr_cls] = count_reg[arr_cls] + 1'b1;
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        total = total + PEAK_W'(count_next[c]);
                    end
                    if (total > peak_reg)
                    begin
                        peak_next = total;
                    end
                end
            end
            OP_SERVE:
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    if (!found && count_reg[c] != '0)
                    begin
                        found = 1'b1;
                        sel_cls = CLS_W'(c);
                    end
                end
                if (!found)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    status = ST_SERVED;
                    store_req.rd_en = a_valid_reg && adv;
                    store_req.rd_addr = {sel_cls, head_reg[sel_cls]};
                    head_next[sel_cls] = ptr_inc(head_reg[sel_cls]);
                    count_next[sel_cls] = count_reg[sel_cls] - 1'b1;
                end
            end
            default:
            begin
                status = ST_ADDED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                count_reg[c] <= '0;
            end
            peak_reg <= '0;
        end
        else if (adv && a_valid_reg)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            peak_reg <= peak_next;
        end
    end

    always_comb
    begin
        b_info.status = status;
        b_info.cls = sel_cls;
        b_info.now = a_reg.time_minutes;
        b_info.report_class = a_reg.report_class;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            b_info.depth[c] = count_next[c];
        end
        b_info.peak = peak_next;
    end

    assign b_valid = a_valid_reg;

endmodule

// ===== rtl/spq_stats.sv =====
// Wait computation, served statistics and result register.
`timescale 1ns / 1ps

module spq_stats
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     b_valid,
    input  stage_b_t b_info,
    input  entry_t   rd_data,
    output logic     rsp_valid,
    output rsp_t     rsp
);

    logic              b_valid_reg;
    stage_b_t          b_reg;
    logic [STAT_W-1:0] served_reg [NUM_CLASSES];
    logic [STAT_W-1:0] served_next [NUM_CLASSES];
    logic [STAT_W-1:0] total_reg;
    logic [STAT_W-1:0] total_next;
    logic [TIME_W-1:0] max_wait_reg;
    logic [TIME_W-1:0] max_wait_next;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic [TIME_W-1:0] wait_val;
    logic              served;
    rsp_t              item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg <= b_info;
        end
    end

    always_comb
    begin
        served = (b_reg.status == ST_SERVED);
        wait_val = '0;
        served_next = served_reg;
        total_next = total_reg;
        max_wait_next = max_wait_reg;
        if (served)
        begin
            if (b_reg.now > rd_data.time_minutes)
            begin
                wait_val = b_reg.now - rd_data.time_minutes;
            end
            if (wait_val > TIME_W'(WAIT_LIMIT))
            begin
                wait_val = TIME_W'(WAIT_LIMIT);
            end
            if (wait_val > max_wait_reg)
            begin
                max_wait_next = wait_val;
            end
            served_next[b_reg.cls] = sat_inc(served_reg[b_reg.cls]);
            total_next = sat_inc(total_reg);
        end
    end

    always_comb
    begin
        item.status = b_reg.status;
        item.served_ticket = served ? 32'(rd_data.ticket) : '0;
        item.served_class = served ? 2'(b_reg.cls) : '0;
        item.wait_time = 11'(wait_val);
        item.depth_emergency = 7'(b_reg.depth[0]);
        item.depth_urgent = 7'(b_reg.depth[1]);
        item.depth_less_urgent = 7'(b_reg.depth[2]);
        item.depth_non_urgent = 7'(b_reg.depth[3]);
        item.total_served = 16'(total_next);
        item.peak_occupancy = 9'(b_reg.peak);
        item.longest_wait = 11'(max_wait_next);
        if (int'(b_reg.report_class) < NUM_CLASSES)
        begin
            item.class_served_count = 16'(served_next[b_reg.report_class]);
        end
        else
        begin
            item.class_served_count = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                served_reg[c] <= '0;
            end
            total_reg <= '0;
            max_wait_reg <= '0;
        end
        else if (adv && b_valid_reg)
        begin
            served_reg <= served_next;
            total_reg <= total_next;
            max_wait_reg <= max_wait_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            rsp_reg <= item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

// ===== rtl/strict_priority_four_queue_scheduler.sv =====
// Strict priority scheduler over four FIFO class queues, 64 items per queue.
// Takes one item per clock while no result is stalled, and returns one
// result per item via an input register, the registered read of the entry
// store (one write and one read port, 256 entries), and the result register.
// A stall on the result side freezes all three stages together, so req_stall
// follows a result that is held. The entry store needs no clearing after
// reset; only occupied entries are ever read.
`timescale 1ns / 1ps
`include "strict_priority_four_queue_scheduler_defines.svh"

module strict_priority_four_queue_scheduler
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic       adv;
    store_req_t store_req;
    entry_t     rd_data;
    logic       b_valid;
    stage_b_t   b_info;

    logic       rsp_other;
    logic       rsp_empty;
    logic       rsp_full;
    logic       unserved_zero;
    logic       depths_zero;
    logic       depth_at_limit;
    logic       depths_bounded;

    assign adv = !rsp_valid || !rsp_stall;
    assign req_stall = !adv;

    spq_queue_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (req_valid),
        .req       (req),
        .store_req (store_req),
        .b_valid   (b_valid),
        .b_info    (b_info)
    );

    spq_store u_store (
        .clk       (clk),
        .store_req (store_req),
        .rd_data   (rd_data)
    );

    spq_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .b_valid   (b_valid),
        .b_info    (b_info),
        .rd_data   (rd_data),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    assign rsp_other = rsp_valid && rsp.status != ST_SERVED;
    assign rsp_empty = rsp_valid && rsp.status == ST_EMPTY;
    assign rsp_full = rsp_valid && rsp.status == ST_FULL;
    assign unserved_zero = rsp.served_ticket == '0 && rsp.served_class == '0
                           && rsp.wait_time == '0;
    assign depths_zero = rsp.depth_emergency == '0 && rsp.depth_urgent == '0
                         && rsp.depth_less_urgent == '0 && rsp.depth_non_urgent == '0;
    assign depth_at_limit = rsp.depth_emergency == 7'(QUEUE_DEPTH)
                            || rsp.depth_urgent == 7'(QUEUE_DEPTH)
                            || rsp.depth_less_urgent == 7'(QUEUE_DEPTH)
                            || rsp.depth_non_urgent == 7'(QUEUE_DEPTH);
    assign depths_bounded = !rsp_valid
                            || (rsp.depth_emergency <= 7'(QUEUE_DEPTH)
                                && rsp.depth_urgent <= 7'(QUEUE_DEPTH)
                                && rsp.depth_less_urgent <= 7'(QUEUE_DEPTH)
                                && rsp.depth_non_urgent <= 7'(QUEUE_DEPTH));

    `SPQ_ASSERT_IMPLIES(a_unserved_zero, rsp_other, unserved_zero, "stray serve fields")
    `SPQ_ASSERT_IMPLIES(a_empty_depths, rsp_empty, depths_zero, "empty with items waiting")
    `SPQ_ASSERT_IMPLIES(a_full_depth, rsp_full, depth_at_limit, "full with no full queue")
    `SPQ_ASSERT_ALWAYS(a_depth_bound, depths_bounded, "queue depth beyond capacity")

endmodule
